FILE: hdl/sfp_pkg.sv
package sfp_pkg;

  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HEADER_FIRST  = 3'd0,
    REG_HEADER_SECOND = 3'd1,
    REG_FRAME_TYPE    = 3'd2,
    REG_PARKED_VALUE  = 3'd3,
    REG_MAX_COMMAND   = 3'd4,
    REG_DEG_PER_CMD   = 3'd5
  } sfp_reg_idx_t;

  localparam logic [7:0] RST_HEADER_FIRST  = 8'hAA;
  localparam logic [7:0] RST_HEADER_SECOND = 8'h55;
  localparam logic [7:0] RST_FRAME_TYPE    = 8'h02;
  localparam logic [7:0] RST_PARKED_VALUE  = 8'h01;
  localparam logic [7:0] RST_MAX_COMMAND   = 8'd4;
  localparam logic [7:0] RST_DEG_PER_CMD   = 8'd90;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] frame_type;
    logic [7:0] parked_value;
    logic [7:0] max_command;
    logic [7:0] degrees_per_command;
  } sfp_cfg_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] byte_value;
  } sfp_item_t;

  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_HEADER2 = 6'b000010,
    PH_TYPE    = 6'b000100,
    PH_COMMAND = 6'b001000,
    PH_STATUS  = 6'b010000,
    PH_CHECK   = 6'b100000
  } sfp_phase_t;

  localparam logic KIND_BYTE       = 1'b0;
  localparam logic KIND_LINE_ERROR = 1'b1;

endpackage

FILE: hdl/sfp_in_if.sv
interface sfp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;

  modport source (output valid, output kind, output byte_value, input ready);
  modport sink (input valid, input kind, input byte_value, output ready);
endinterface

FILE: hdl/sfp_out_if.sv
interface sfp_out_if;
  logic        valid;
  logic        ready;
  logic        frame_good;
  logic        frame_bad;
  logic        start_request;
  logic [15:0] target_degrees;
  logic [31:0] received_bytes;
  logic [31:0] valid_frames;
  logic [31:0] bad_frames;

  modport source (
    output valid, output frame_good, output frame_bad, output start_request,
    output target_degrees, output received_bytes, output valid_frames,
    output bad_frames, input ready
  );
  modport sink (
    input valid, input frame_good, input frame_bad, input start_request,
    input target_degrees, input received_bytes, input valid_frames,
    input bad_frames, output ready
  );
endinterface

FILE: hdl/sfp_cfg_regs.sv
module sfp_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [sfp_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [sfp_pkg::CFG_DATA_W-1:0]       cfg_data,
  output sfp_pkg::sfp_cfg_t                    cfg
);

  sfp_pkg::sfp_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first        <= sfp_pkg::RST_HEADER_FIRST;
      cfg_r.header_second       <= sfp_pkg::RST_HEADER_SECOND;
      cfg_r.frame_type          <= sfp_pkg::RST_FRAME_TYPE;
      cfg_r.parked_value        <= sfp_pkg::RST_PARKED_VALUE;
      cfg_r.max_command         <= sfp_pkg::RST_MAX_COMMAND;
      cfg_r.degrees_per_command <= sfp_pkg::RST_DEG_PER_CMD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfp_pkg::REG_HEADER_FIRST:  cfg_r.header_first        <= cfg_data;
        sfp_pkg::REG_HEADER_SECOND: cfg_r.header_second       <= cfg_data;
        sfp_pkg::REG_FRAME_TYPE:    cfg_r.frame_type          <= cfg_data;
        sfp_pkg::REG_PARKED_VALUE:  cfg_r.parked_value        <= cfg_data;
        sfp_pkg::REG_MAX_COMMAND:   cfg_r.max_command         <= cfg_data;
        sfp_pkg::REG_DEG_PER_CMD:   cfg_r.degrees_per_command <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/sfp_in_stage.sv
module sfp_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  sfp_in_if.sink              in_ch,
  input  logic                take,
  output sfp_pkg::sfp_item_t  item
);

  sfp_pkg::sfp_item_t item_r;
  logic               in_ready;

  assign in_ready    = !item_r.valid || take;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (in_ready) begin
      item_r.valid <= in_ch.valid;
    end
    if (in_ready && in_ch.valid) begin
      item_r.kind       <= in_ch.kind;
      item_r.byte_value <= in_ch.byte_value;
    end
  end

  assign item = item_r;

endmodule

FILE: hdl/sfp_parser.sv
module sfp_parser #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sfp_pkg::sfp_cfg_t   cfg,
  input  sfp_pkg::sfp_item_t  item,
  output logic                take,
  sfp_out_if.source           out_ch
);

  sfp_pkg::sfp_phase_t    phase_r, phase_nxt;
  logic [7:0]             command_r, command_nxt;
  logic [7:0]             status_r, status_nxt;
  logic                   latched_r, latched_nxt;
  logic [15:0]            degrees_r, degrees_nxt;
  logic [COUNT_WIDTH-1:0] bytes_r, bytes_nxt;
  logic [COUNT_WIDTH-1:0] good_cnt_r, good_cnt_nxt;
  logic [COUNT_WIDTH-1:0] bad_cnt_r, bad_cnt_nxt;

  logic       out_valid_r;
  logic       good_r, good_nxt;
  logic       bad_r, bad_nxt;
  logic       start_r, start_nxt;
  logic [7:0] sum;
  logic       frame_ok;
  logic [7:0] b;
  logic       step;

  assign take = !out_valid_r || out_ch.ready;
  assign step = take && item.valid;
  assign b    = item.byte_value;

  assign sum = cfg.header_first + cfg.header_second + cfg.frame_type + command_r + status_r;
  assign frame_ok = (b == sum) && (status_r == cfg.parked_value) &&
                    (command_r != 8'd0) && (command_r <= cfg.max_command);

  always_comb begin
    phase_nxt    = phase_r;
    command_nxt  = command_r;
    status_nxt   = status_r;
    latched_nxt  = latched_r;
    degrees_nxt  = degrees_r;
    bytes_nxt    = bytes_r;
    good_cnt_nxt = good_cnt_r;
    bad_cnt_nxt  = bad_cnt_r;
    good_nxt     = 1'b0;
    bad_nxt      = 1'b0;
    start_nxt    = 1'b0;
    if (item.kind == sfp_pkg::KIND_LINE_ERROR) begin
      phase_nxt = sfp_pkg::PH_HUNT;
    end else begin
      bytes_nxt = bytes_r + 1'b1;
      unique case (phase_r)
        sfp_pkg::PH_HUNT: begin
          if (b == cfg.header_first) phase_nxt = sfp_pkg::PH_HEADER2;
        end
        sfp_pkg::PH_HEADER2: begin
          if (b == cfg.header_second) phase_nxt = sfp_pkg::PH_TYPE;
          else if (b != cfg.header_first) phase_nxt = sfp_pkg::PH_HUNT;
        end
        sfp_pkg::PH_TYPE: begin
          if (b == cfg.frame_type) phase_nxt = sfp_pkg::PH_COMMAND;
          else if (b == cfg.header_first) phase_nxt = sfp_pkg::PH_HEADER2;
          else phase_nxt = sfp_pkg::PH_HUNT;
        end
        sfp_pkg::PH_COMMAND: begin
          command_nxt = b;
          phase_nxt   = sfp_pkg::PH_STATUS;
        end
        sfp_pkg::PH_STATUS: begin
          status_nxt = b;
          phase_nxt  = sfp_pkg::PH_CHECK;
        end
        sfp_pkg::PH_CHECK: begin
          if (frame_ok) begin
            good_nxt     = 1'b1;
            good_cnt_nxt = good_cnt_r + 1'b1;
            if (!latched_r) begin
              latched_nxt = 1'b1;
              degrees_nxt = {8'd0, command_r} * {8'd0, cfg.degrees_per_command};
              start_nxt   = 1'b1;
            end
          end else begin
            bad_nxt     = 1'b1;
            bad_cnt_nxt = bad_cnt_r + 1'b1;
          end
          phase_nxt = (b == cfg.header_first) ? sfp_pkg::PH_HEADER2 : sfp_pkg::PH_HUNT;
        end
        default: phase_nxt = sfp_pkg::PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sfp_pkg::PH_HUNT;
      command_r   <= 8'd0;
      status_r    <= 8'd0;
      latched_r   <= 1'b0;
      degrees_r   <= 16'd0;
      bytes_r     <= '0;
      good_cnt_r  <= '0;
      bad_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) out_valid_r <= item.valid;
      if (step) begin
        phase_r    <= phase_nxt;
        command_r  <= command_nxt;
        status_r   <= status_nxt;
        latched_r  <= latched_nxt;
        degrees_r  <= degrees_nxt;
        bytes_r    <= bytes_nxt;
        good_cnt_r <= good_cnt_nxt;
        bad_cnt_r  <= bad_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      good_r  <= good_nxt;
      bad_r   <= bad_nxt;
      start_r <= start_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.frame_good     = good_r;
  assign out_ch.frame_bad      = bad_r;
  assign out_ch.start_request  = start_r;
  assign out_ch.target_degrees = degrees_r;
  assign out_ch.received_bytes = 32'(bytes_r);
  assign out_ch.valid_frames   = 32'(good_cnt_r);
  assign out_ch.bad_frames     = 32'(bad_cnt_r);

endmodule

FILE: hdl/sync_frame_parser_checksum_unit.sv
// an input transaction passes through the input register, then the result register, before its result is valid
// throughput: one transaction per cycle unless output back-pressure stalls; the phase update is a single pass of logic
// input register keeps accepting input while a result waits, stalls only when both stages hold
// reset: synchronous active-low rst_n; config returns to defaults, parser to header hunt,
// counters and the start latch to zero
module sync_frame_parser_checksum_unit #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sfp_in_if.sink                          in_ch,
  sfp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [sfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  sfp_pkg::sfp_cfg_t  cfg;
  sfp_pkg::sfp_item_t item;
  logic               take;

  sfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfp_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .item  (item)
  );

  sfp_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .item   (item),
    .take   (take),
    .out_ch (out_ch)
  );

  a_good_bad_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.frame_good && out_ch.frame_bad))
    else $error("frame reported both good and bad");

  a_start_needs_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.start_request |-> out_ch.frame_good)
    else $error("start request without a good frame");

  a_start_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.start_request
      |=> !(out_ch.valid && out_ch.start_request))
    else $error("start request repeated");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled while output free");

endmodule
